// File: hw/rtl/car_pkg.sv
// Shared types and constants of the CAR cache replacement block.
package car_pkg;

    // List a slot belongs to.
    typedef enum logic [2:0] {
        L_FREE = 3'd0,
        L_T1   = 3'd1,
        L_T2   = 3'd2,
        L_B1   = 3'd3,
        L_B2   = 3'd4
    } t_list;

    // What follows an unlink.
    typedef enum logic [1:0] {
        PF_FREE,
        PF_CLOCK,
        PF_ALLOC
    } t_post;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SRCH,
        ST_DISPATCH,
        ST_DIV,
        ST_ADAPT,
        ST_EVLOOP,
        ST_UNL_RD,
        ST_UNL_EX,
        ST_POST,
        ST_TRIM,
        ST_FREECHK,
        ST_ALLOC,
        ST_DONE
    } t_state;

    // Ghost classes reported with a result.
    localparam logic [1:0] GC_NONE = 2'd0;
    localparam logic [1:0] GC_B1   = 2'd1;
    localparam logic [1:0] GC_B2   = 2'd2;

    // Register indexes and reset values.
    localparam logic       CFG_CAPACITY = 1'b0;
    localparam logic       CFG_TARGET   = 1'b1;
    localparam logic [8:0] CAP_RESET    = 9'd256;
    localparam logic       MODE_ACCESS  = 1'b0;
    localparam logic       MODE_REMOVE  = 1'b1;

endpackage

// File: hw/rtl/car_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module car_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Read returns the contents before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/car_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module car_div #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int IW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [IW-1:0] r_i, n_i;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_den, n_den;
    logic [W:0]    w_shift;

    // One shift and conditional subtract per step.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_i     = r_i;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        w_shift = {r_rem[W-1:0], r_quo[W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_i    = IW'(W);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_shift - {1'b0, r_den};
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_i = r_i - 1'b1;
            if (r_i == IW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_i    <= n_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: hw/rtl/car_cache_replacement_core.sv
// CAR cache replacement directory: slot memories, list sequencer and config port.
//
// A request is transferred when start is high and busy is low; it carries a
// mode (access or remove) and a 64-bit key. Exactly one result follows: it is
// shown for one cycle with o_valid high, and the receiver cannot stall it.
// Registers capacity (address 0) and initial_target (address 4) are written
// through the APB port; the user must write them only while busy is low,
// which the block itself does not enforce. pready is always high.
// Each request first scans the key and list memories one slot per cycle. A key
// held in slot k ends the scan once slot k has been compared; otherwise all
// 2*CAPACITY slots are read. Every list operation is a memory read, an unlink
// and a relink. A ghost hit adds a divide of one bit per cycle over the count
// width, an adapt step and the ghost release. After reset the block runs a
// clearing pass over all 2*CAPACITY slots of the list and link memories with
// busy high; register writes are taken meanwhile.
module car_cache_replacement_core
    import car_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [63:0] i_key,
    output logic        o_valid,
    output logic        o_hit,
    output logic [1:0]  o_ghost_class,
    output logic        o_evicted_valid,
    output logic [63:0] o_evicted_key,
    output logic        o_removed_found,
    output logic [8:0]  o_target_now,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NSLOT = 2 * CAPACITY;
    localparam int SW    = $clog2(NSLOT);
    localparam int CW    = $clog2(NSLOT + 1);
    localparam int SUMW  = (CW + 2 > 11) ? CW + 2 : 11;

    // Memory ports.
    logic [SW-1:0] w_raddr;
    logic [63:0]   rd_key;
    logic [3:0]    rd_lr;
    logic [SW-1:0] rd_nx, rd_pv;
    logic          key_we, lr_we, nx_we, pv_we;
    logic [SW-1:0] key_wa, lr_wa, nx_wa, pv_wa;
    logic [63:0]   key_wd;
    logic [3:0]    lr_wd;
    logic [SW-1:0] nx_wd, pv_wd;

    car_ram #(.W(64), .D(NSLOT)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_wa), .i_wdata(key_wd),
        .i_raddr(w_raddr), .o_rdata(rd_key));
    car_ram #(.W(4), .D(NSLOT)) u_lr (
        .i_clk(i_clk), .i_we(lr_we), .i_waddr(lr_wa), .i_wdata(lr_wd),
        .i_raddr(w_raddr), .o_rdata(rd_lr));
    car_ram #(.W(SW), .D(NSLOT)) u_nx (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(w_raddr), .o_rdata(rd_nx));
    car_ram #(.W(SW), .D(NSLOT)) u_pv (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(w_raddr), .o_rdata(rd_pv));

    // Control registers.
    t_state        r_state, n_state;
    t_state        r_ret, n_ret;
    t_post         r_post, n_post;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_pend, n_pend;
    logic [SW-1:0] r_head [5];
    logic [SW-1:0] n_head [5];
    logic [SW-1:0] r_tail [5];
    logic [SW-1:0] n_tail [5];
    logic [CW-1:0] r_cntl [5];
    logic [CW-1:0] n_cntl [5];
    logic [8:0]    r_cap, r_init, r_p, n_p;
    logic          div_start, div_done;
    logic [CW-1:0] div_num, div_den, div_quo;

    // Payload registers.
    logic [SW-1:0] r_paddr, n_paddr;
    logic          r_mode, n_mode;
    logic [63:0]   r_key, n_key;
    logic          r_found, n_found;
    logic [SW-1:0] r_fs, n_fs;
    t_list         r_flist, n_flist;
    logic [SW-1:0] r_s, n_s;
    logic          r_use_t1, n_use_t1;
    logic [1:0]    r_gc, n_gc;
    logic          r_hit, n_hit;
    logic          r_ev, n_ev;
    logic [63:0]   r_ekey, n_ekey;
    logic          r_rem, n_rem;
    logic          r_rd_ref, n_rd_ref;
    logic [63:0]   r_rd_key, n_rd_key;

    car_div #(.W(CW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quo(div_quo));

    // Fixed-place list counts and derived sizes.
    logic [SUMW-1:0] t1, t2, b1, b2, w_c, w_lim, w_d, w_psum;
    logic            cfg_wr;
    t_list           w_l, w_rd_list;
    logic            w_push_head;
    logic [SW-1:0]   w_head, w_tail;
    logic [CW-1:0]   w_cnt;

    assign t1 = SUMW'(r_cntl[L_T1]);
    assign t2 = SUMW'(r_cntl[L_T2]);
    assign b1 = SUMW'(r_cntl[L_B1]);
    assign b2 = SUMW'(r_cntl[L_B2]);
    assign w_rd_list = t_list'(rd_lr[3:1]);
    assign cfg_wr = psel && penable && pwrite && pready;

    // Effective capacity (zero taken as 1, clamped to the built size), clock-hand limit and adapt step.
    always_comb begin
        w_c = SUMW'(r_cap);
        if (w_c == '0) begin
            w_c = SUMW'(1);
        end else if (w_c > SUMW'(CAPACITY)) begin
            w_c = SUMW'(CAPACITY);
        end
        w_lim = (r_p == '0) ? SUMW'(1) : SUMW'(r_p);
        w_d   = (div_den == '0 || div_quo == '0) ? SUMW'(1) : SUMW'(div_quo);
        w_psum = SUMW'(r_p) + w_d;
    end

    // The one list whose head, tail and count the current step works on.
    always_comb begin
        w_push_head = 1'b0;
        if (r_state == ST_UNL_EX) begin
            w_l = w_rd_list;
        end else begin
            unique case (r_post)
                PF_FREE:  w_l = L_FREE;
                PF_CLOCK: begin
                    if (!r_rd_ref) begin
                        w_l = r_use_t1 ? L_B1 : L_B2;
                        w_push_head = 1'b1;
                    end else begin
                        w_l = L_T2;
                    end
                end
                PF_ALLOC: w_l = (r_gc != GC_NONE) ? L_T2 : L_T1;
                default:  w_l = L_FREE;
            endcase
        end
        w_head = r_head[w_l];
        w_tail = r_tail[w_l];
        w_cnt  = r_cntl[w_l];
    end

    // Sequencer: next state, list updates and memory writes.
    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_post = r_post;
        n_cnt = r_cnt;  n_pend = 1'b0;  n_paddr = r_paddr;
        n_head = r_head;  n_tail = r_tail;  n_cntl = r_cntl;
        n_p = r_p;
        n_mode = r_mode;  n_key = r_key;  n_found = r_found;
        n_fs = r_fs;  n_flist = r_flist;  n_s = r_s;  n_use_t1 = r_use_t1;
        n_gc = r_gc;  n_hit = r_hit;  n_ev = r_ev;  n_ekey = r_ekey;
        n_rem = r_rem;  n_rd_ref = r_rd_ref;  n_rd_key = r_rd_key;
        w_raddr = r_s;
        key_we = 1'b0;  key_wa = r_s;  key_wd = r_key;
        lr_we = 1'b0;  lr_wa = r_s;  lr_wd = {L_FREE, 1'b0};
        nx_we = 1'b0;  nx_wa = r_s;  nx_wd = r_s;
        pv_we = 1'b0;  pv_wa = r_s;  pv_wd = r_s;
        div_start = 1'b0;
        div_num = r_cntl[L_B2];
        div_den = r_cntl[L_B1];
        if (r_gc == GC_B2) begin
            div_num = r_cntl[L_B1];
            div_den = r_cntl[L_B2];
        end

        unique case (r_state)
            // Chain every slot into the free list.
            ST_CLR: begin
                lr_we = 1'b1;
                lr_wa = r_cnt[SW-1:0];
                lr_wd = {L_FREE, 1'b0};
                nx_we = 1'b1;
                nx_wa = r_cnt[SW-1:0];
                nx_wd = (r_cnt == CW'(NSLOT - 1)) ? '0 : SW'(r_cnt + 1'b1);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(NSLOT - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_key   = i_key;
                    n_hit   = 1'b0;
                    n_gc    = GC_NONE;
                    n_ev    = 1'b0;
                    n_ekey  = '0;
                    n_rem   = 1'b0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_state = ST_SRCH;
                end
            end
            // Scan the slots until a match, one read per cycle, compare each in the cycle after its read.
            ST_SRCH: begin
                w_raddr = r_cnt[SW-1:0];
                if (r_cnt < CW'(NSLOT)) begin
                    n_pend  = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_paddr = r_cnt[SW-1:0];
                end
                if (r_pend && w_rd_list != L_FREE && rd_key == r_key) begin
                    n_found = 1'b1;
                    n_fs    = r_paddr;
                    n_flist = w_rd_list;
                    n_pend  = 1'b0;
                    n_state = ST_DISPATCH;
                end else if (!r_pend && r_cnt == CW'(NSLOT)) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_s = r_fs;
                if (r_mode == MODE_REMOVE) begin
                    if (r_found) begin
                        n_rem   = 1'b1;
                        n_post  = PF_FREE;
                        n_ret   = ST_DONE;
                        n_state = ST_UNL_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (r_found && (r_flist == L_T1 || r_flist == L_T2)) begin
                    lr_we   = 1'b1;
                    lr_wa   = r_fs;
                    lr_wd   = {r_flist, 1'b1};
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else if (r_found) begin
                    n_gc      = (r_flist == L_B1) ? GC_B1 : GC_B2;
                    div_start = 1'b1;
                    div_num   = (r_flist == L_B1) ? r_cntl[L_B2] : r_cntl[L_B1];
                    div_den   = (r_flist == L_B1) ? r_cntl[L_B1] : r_cntl[L_B2];
                    n_state   = ST_DIV;
                end else begin
                    n_state = ST_EVLOOP;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_ADAPT;
                end
            end
            // Adapt the target, then free the ghost slot.
            ST_ADAPT: begin
                if (r_gc == GC_B1) begin
                    n_p = (w_psum < w_c) ? w_psum[8:0] : w_c[8:0];
                end else begin
                    n_p = (SUMW'(r_p) > w_d) ? 9'(SUMW'(r_p) - w_d) : '0;
                end
                n_post  = PF_FREE;
                n_ret   = ST_EVLOOP;
                n_state = ST_UNL_RD;
            end
            // Clock hand: pick the head of T1 or T2 while the cache is full.
            ST_EVLOOP: begin
                if (t1 + t2 >= w_c) begin
                    n_use_t1 = (t1 >= w_lim && t1 != '0) || t2 == '0;
                    n_s      = n_use_t1 ? r_head[L_T1] : r_head[L_T2];
                    n_post   = PF_CLOCK;
                    n_state  = ST_UNL_RD;
                end else begin
                    n_state = ST_FREECHK;
                end
            end
            ST_UNL_RD: begin
                w_raddr = r_s;
                n_state = ST_UNL_EX;
            end
            // Unlink the slot from its list.
            ST_UNL_EX: begin
                if (w_cnt != '0) begin
                    if (w_head == r_s) begin
                        n_head[w_l] = rd_nx;
                    end else begin
                        nx_we = 1'b1;
                        nx_wa = rd_pv;
                        nx_wd = rd_nx;
                    end
                    if (w_tail == r_s) begin
                        n_tail[w_l] = rd_pv;
                    end else begin
                        pv_we = 1'b1;
                        pv_wa = rd_nx;
                        pv_wd = rd_pv;
                    end
                    n_cntl[w_l] = w_cnt - 1'b1;
                end
                n_rd_ref = rd_lr[0];
                n_rd_key = rd_key;
                n_state  = ST_POST;
            end
            // Link the slot into its new list.
            ST_POST: begin
                lr_we = 1'b1;
                lr_wa = r_s;
                lr_wd = {w_l, 1'b0};
                if (w_push_head) begin
                    if (w_cnt != '0) begin
                        pv_we = 1'b1;  pv_wa = w_head;  pv_wd = r_s;
                        nx_we = 1'b1;  nx_wa = r_s;     nx_wd = w_head;
                    end else begin
                        n_tail[w_l] = r_s;
                    end
                    n_head[w_l] = r_s;
                end else begin
                    if (w_cnt != '0) begin
                        nx_we = 1'b1;  nx_wa = w_tail;  nx_wd = r_s;
                        pv_we = 1'b1;  pv_wa = r_s;     pv_wd = w_tail;
                    end else begin
                        n_head[w_l] = r_s;
                    end
                    n_tail[w_l] = r_s;
                end
                n_cntl[w_l] = w_cnt + 1'b1;
                unique case (r_post)
                    PF_FREE:  n_state = r_ret;
                    PF_CLOCK: begin
                        if (!r_rd_ref) begin
                            n_ev    = 1'b1;
                            n_ekey  = r_rd_key;
                            n_state = ST_TRIM;
                        end else begin
                            n_state = ST_EVLOOP;
                        end
                    end
                    PF_ALLOC: begin
                        key_we  = 1'b1;
                        key_wa  = r_s;
                        key_wd  = r_key;
                        n_state = ST_DONE;
                    end
                    default:  n_state = ST_DONE;
                endcase
            end
            // After a plain-miss eviction, drop an LRU ghost if the
            // directory has grown too large.
            ST_TRIM: begin
                n_state = ST_EVLOOP;
                n_post  = PF_FREE;
                n_ret   = ST_EVLOOP;
                if (r_gc == GC_NONE) begin
                    if (t1 + b1 >= w_c && b1 != '0) begin
                        n_s     = r_tail[L_B1];
                        n_state = ST_UNL_RD;
                    end else if (t1 + t2 + b1 + b2 >= {w_c[SUMW-2:0], 1'b0}
                                 && b2 != '0) begin
                        n_s     = r_tail[L_B2];
                        n_state = ST_UNL_RD;
                    end
                end
            end
            // Without a free slot, give up the oldest ghost.
            ST_FREECHK: begin
                n_state = ST_ALLOC;
                n_post  = PF_FREE;
                n_ret   = ST_ALLOC;
                if (r_cntl[L_FREE] == '0) begin
                    if (b2 != '0) begin
                        n_s     = r_tail[L_B2];
                        n_state = ST_UNL_RD;
                    end else if (b1 != '0) begin
                        n_s     = r_tail[L_B1];
                        n_state = ST_UNL_RD;
                    end
                end
            end
            ST_ALLOC: begin
                if (r_cntl[L_FREE] != '0) begin
                    n_s     = r_head[L_FREE];
                    n_post  = PF_ALLOC;
                    n_state = ST_UNL_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase

        // Writing the initial target also loads the live target.
        if (cfg_wr && paddr[2] == CFG_TARGET) begin
            n_p = pwdata[8:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ret   <= ST_DONE;
            r_post  <= PF_FREE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            for (int i = 0; i < 5; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= (i == L_FREE) ? SW'(NSLOT - 1) : '0;
                r_cntl[i] <= (i == L_FREE) ? CW'(NSLOT) : '0;
            end
            r_cap  <= CAP_RESET;
            r_init <= '0;
            r_p    <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_post  <= n_post;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cntl  <= n_cntl;
            r_p     <= n_p;
            if (cfg_wr && paddr[2] == CFG_CAPACITY) begin
                r_cap <= pwdata[8:0];
            end
            if (cfg_wr && paddr[2] == CFG_TARGET) begin
                r_init <= pwdata[8:0];
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        r_paddr  <= n_paddr;
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_found  <= n_found;
        r_fs     <= n_fs;
        r_flist  <= n_flist;
        r_s      <= n_s;
        r_use_t1 <= n_use_t1;
        r_gc     <= n_gc;
        r_hit    <= n_hit;
        r_ev     <= n_ev;
        r_ekey   <= n_ekey;
        r_rem    <= n_rem;
        r_rd_ref <= n_rd_ref;
        r_rd_key <= n_rd_key;
    end

    // Ports.
    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = (r_state == ST_DONE);
    assign o_hit           = r_hit;
    assign o_ghost_class   = r_gc;
    assign o_evicted_valid = r_ev;
    assign o_evicted_key   = r_ekey;
    assign o_removed_found = r_rem;
    assign o_target_now    = r_p;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == CFG_TARGET) ? {23'd0, r_init} : {23'd0, r_cap};
endmodule

// File: hw/rtl/car_chk.sv
// Port-level checker for the CAR cache replacement block, with its bind.
module car_chk
    import car_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_hit,
    input logic [1:0]  o_ghost_class,
    input logic        o_evicted_valid,
    input logic [63:0] o_evicted_key,
    input logic        o_removed_found
);
    // A transferred request keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy low after request transfer");

    // A result strobe lasts one cycle.
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // A hit neither adapts nor evicts.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_ghost_class == GC_NONE && !o_evicted_valid
                             && !o_removed_found) else $error("hit with side effects");

    // No eviction means a zero evicted key.
    a_ekey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted_valid |-> o_evicted_key == 64'd0)
        else $error("evicted key without eviction");
endmodule

bind car_cache_replacement_core car_chk u_car_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_hit(o_hit), .o_ghost_class(o_ghost_class),
    .o_evicted_valid(o_evicted_valid), .o_evicted_key(o_evicted_key),
    .o_removed_found(o_removed_found));

// File: tb/tb.sv
// Self-checking testbench for the CAR cache replacement core, with a built-in list predictor.
`timescale 1ns / 100ps

module tb;
    import car_pkg::*;

    localparam int CAP   = 256;
    localparam int NSLOT = 2 * CAP;

    typedef struct {
        logic        mode;
        logic [63:0] key;
    } t_request;

    typedef struct {
        logic        hit;
        logic [1:0]  ghost;
        logic        ev_valid;
        logic [63:0] ev_key;
        logic        rem_found;
        logic [8:0]  target;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_mode = 1'b0;
    logic [63:0] i_key = '0;
    logic        o_valid;
    logic        o_hit;
    logic [1:0]  o_ghost_class;
    logic        o_evicted_valid;
    logic [63:0] o_evicted_key;
    logic        o_removed_found;
    logic [8:0]  o_target_now;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    car_cache_replacement_core #(.CAPACITY(CAP)) dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: slot memories, list pointers, target and registers.
    logic [63:0] pk_key  [NSLOT];
    t_list       pk_list [NSLOT];
    logic        pk_ref  [NSLOT];
    int unsigned pk_next [NSLOT];
    int unsigned pk_prev [NSLOT];
    int unsigned lhead [5];
    int unsigned ltail [5];
    int unsigned lcount [5];
    int unsigned tgt_p;
    int unsigned cap_reg;

    t_request    pending_requests[$];
    t_outcome    expected_outcomes[$];
    int          error_count = 0;
    int          idle_pct = 30;
    logic        took = 1'b0;

    function automatic void dir_unlink(int unsigned s);
        int unsigned l, n, p;
        l = pk_list[s];
        n = pk_next[s];
        p = pk_prev[s];
        if (lcount[l] == 0) return;
        if (lhead[l] == s) lhead[l] = n; else pk_next[p] = n;
        if (ltail[l] == s) ltail[l] = p; else pk_prev[n] = p;
        lcount[l]--;
    endfunction

    function automatic void dir_push(int unsigned s, t_list l, bit at_head);
        pk_list[s] = l;
        if (lcount[l] == 0) begin
            lhead[l] = s;
            ltail[l] = s;
        end else if (at_head) begin
            pk_prev[lhead[l]] = s;
            pk_next[s] = lhead[l];
            lhead[l] = s;
        end else begin
            pk_next[ltail[l]] = s;
            pk_prev[s] = ltail[l];
            ltail[l] = s;
        end
        lcount[l]++;
    endfunction

    function automatic void dir_free(int unsigned s);
        dir_unlink(s);
        pk_ref[s] = 1'b0;
        dir_push(s, L_FREE, 1'b0);
    endfunction

    function automatic void drop_oldest_ghost(t_list l);
        if (lcount[l] != 0) dir_free(ltail[l]);
    endfunction

    // Clock hand: second-chance referenced heads into T2 until one is evicted.
    function automatic logic [63:0] run_clock_hand();
        int unsigned lim, s;
        bit from_t1;
        forever begin
            lim = (tgt_p < 1) ? 1 : tgt_p;
            if (lcount[L_T1] == 0 && lcount[L_T2] == 0) return '0;
            from_t1 = (lcount[L_T1] >= lim && lcount[L_T1] > 0) || lcount[L_T2] == 0;
            s = from_t1 ? lhead[L_T1] : lhead[L_T2];
            dir_unlink(s);
            if (!pk_ref[s]) begin
                dir_push(s, from_t1 ? L_B1 : L_B2, 1'b1);
                return pk_key[s];
            end
            pk_ref[s] = 1'b0;
            dir_push(s, L_T2, 1'b0);
        end
    endfunction

    // Works out the outcome of one request and updates the directory.
    function automatic t_outcome predict_request(t_request rq);
        t_outcome r;
        int unsigned c, s, d, b1, b2;
        c = (cap_reg < 1) ? 1 : (cap_reg > CAP) ? CAP : cap_reg;
        r = '{default: '0};
        s = NSLOT;
        for (int i = 0; i < NSLOT; i++)
            if (s == NSLOT && pk_list[i] != L_FREE && pk_key[i] == rq.key) s = i;
        if (rq.mode == MODE_REMOVE) begin
            if (s < NSLOT) begin
                dir_free(s);
                r.rem_found = 1'b1;
            end
        end else if (s < NSLOT && (pk_list[s] == L_T1 || pk_list[s] == L_T2)) begin
            pk_ref[s] = 1'b1;
            r.hit = 1'b1;
        end else begin
            if (s < NSLOT) begin
                b1 = lcount[L_B1];
                b2 = lcount[L_B2];
                if (pk_list[s] == L_B1) begin
                    r.ghost = GC_B1;
                    d = b1 ? b2 / b1 : 0;
                    if (d < 1) d = 1;
                    tgt_p = (tgt_p + d < c) ? tgt_p + d : c;
                end else begin
                    r.ghost = GC_B2;
                    d = b2 ? b1 / b2 : 0;
                    if (d < 1) d = 1;
                    tgt_p = (tgt_p > d) ? tgt_p - d : 0;
                end
                dir_free(s);
            end
            while (lcount[L_T1] + lcount[L_T2] >= c) begin
                r.ev_key = run_clock_hand();
                r.ev_valid = 1'b1;
                if (r.ghost == GC_NONE) begin
                    if (lcount[L_T1] + lcount[L_B1] >= c && lcount[L_B1] > 0)
                        drop_oldest_ghost(L_B1);
                    else if (lcount[L_T1] + lcount[L_T2] + lcount[L_B1] + lcount[L_B2] >= 2 * c
                             && lcount[L_B2] > 0)
                        drop_oldest_ghost(L_B2);
                end
            end
            if (lcount[L_FREE] == 0)
                drop_oldest_ghost(lcount[L_B2] > 0 ? L_B2 : L_B1);
            if (lcount[L_FREE] > 0) begin
                s = lhead[L_FREE];
                dir_unlink(s);
                pk_key[s] = rq.key;
                pk_ref[s] = 1'b0;
                dir_push(s, (r.ghost != GC_NONE) ? L_T2 : L_T1, 1'b0);
            end
        end
        r.target = tgt_p[8:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Monitor: checks each result transfer, then predicts any accepted request.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, got key %0h", $time, o_evicted_key);
                error_count++;
            end else begin
                e = expected_outcomes.pop_front();
                check_field("hit", e.hit, o_hit);
                check_field("ghost_class", e.ghost, o_ghost_class);
                check_field("evicted_valid", e.ev_valid, o_evicted_valid);
                check_field("evicted_key", e.ev_key, o_evicted_key);
                check_field("removed_found", e.rem_found, o_removed_found);
                check_field("target_now", e.target, o_target_now);
            end
        end
        took <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            expected_outcomes.push_back(predict_request('{i_mode, i_key}));
    end

    // Driver: holds a request until it is transferred, idles at random.
    always @(negedge i_clk) begin
        t_request rq;
        if (i_rst_n) begin
            if (start && !took) begin
                // Still waiting for the transfer.
            end else if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                rq = pending_requests.pop_front();
                start <= 1'b1;
                i_mode <= rq.mode;
                i_key <= rq.key;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic reg_write(logic idx, int unsigned value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == CFG_CAPACITY) begin
            cap_reg = value & 9'h1FF;
        end else begin
            tgt_p = value & 9'h1FF;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || start || expected_outcomes.size() > 0 || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic add_request(logic mode, logic [63:0] key);
        pending_requests.push_back('{mode, key});
    endtask

    // Random phase: mostly keys from a small pool so that hits and ghost hits occur.
    task automatic random_phase(int unsigned count, int unsigned pool, logic [63:0] base);
        logic [63:0] k;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) k = {$urandom, $urandom};
            else k = base + $urandom_range(0, pool - 1);
            add_request($urandom_range(0, 99) < 12, k);
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            pk_key[i] = '0;
            pk_list[i] = L_FREE;
            pk_ref[i] = 1'b0;
            pk_next[i] = (i + 1) % NSLOT;
            pk_prev[i] = 0;
        end
        for (int i = 0; i < 5; i++) begin
            lhead[i] = 0;
            ltail[i] = 0;
            lcount[i] = 0;
        end
        ltail[L_FREE] = NSLOT - 1;
        lcount[L_FREE] = NSLOT;
        cap_reg = CAP_RESET;
        tgt_p = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // Directed part on a two-entry cache: extremes, hits, evictions, ghosts, removes.
        reg_write(CFG_CAPACITY, 2);
        reg_write(CFG_TARGET, 0);
        add_request(MODE_ACCESS, 64'h0);
        add_request(MODE_ACCESS, '1);
        add_request(MODE_ACCESS, 64'h0);
        add_request(MODE_ACCESS, 64'h5);
        add_request(MODE_ACCESS, '1);
        add_request(MODE_ACCESS, 64'h6);
        add_request(MODE_ACCESS, 64'h5);
        add_request(MODE_ACCESS, 64'h0);
        add_request(MODE_ACCESS, 64'h7);
        add_request(MODE_ACCESS, '1);
        add_request(MODE_REMOVE, 64'h6);
        add_request(MODE_REMOVE, 64'h5);
        add_request(MODE_REMOVE, 64'h1234);
        add_request(MODE_REMOVE, '1);
        add_request(MODE_ACCESS, 64'hAAAA_5555_AAAA_5555);
        add_request(MODE_ACCESS, 64'h5555_AAAA_5555_AAAA);
        add_request(MODE_ACCESS, 64'h0);
        random_phase(110, 8, 64'h10);
        wait_drained();

        // Target above capacity.
        reg_write(CFG_CAPACITY, 16);
        reg_write(CFG_TARGET, 256);
        random_phase(110, 48, 64'h100);
        wait_drained();

        // Capacity lowered below the current occupancy.
        idle_pct = 75;
        reg_write(CFG_CAPACITY, 4);
        reg_write(CFG_TARGET, 1);
        random_phase(110, 12, 64'h100);
        wait_drained();

        reg_write(CFG_CAPACITY, 64);
        reg_write(CFG_TARGET, 32);
        random_phase(110, 200, 64'h1000);
        wait_drained();

        // Single-entry cache, then the full capacity.
        idle_pct = 0;
        reg_write(CFG_CAPACITY, 1);
        reg_write(CFG_TARGET, 0);
        random_phase(110, 4, 64'h20);
        wait_drained();

        reg_write(CFG_CAPACITY, 256);
        reg_write(CFG_TARGET, 128);
        random_phase(110, 400, 64'h2000);
        wait_drained();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/car_pkg.sv
hw/rtl/car_ram.sv
hw/rtl/car_div.sv
hw/rtl/car_cache_replacement_core.sv
hw/rtl/car_chk.sv
tb/tb.sv
